### hdl/nvm_pkg.sv
// ----------------------------------------------------------------------------
// nvm_pkg
// shared widths, defaults and cell command types for the nearest value matcher
// ----------------------------------------------------------------------------
`default_nettype none

package nvm_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned VAL_W        = 31;
  localparam int unsigned TOTAL_W      = 63;
  localparam int unsigned FILL_W       = 11;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_INS,
    OP_DEL_LO,
    OP_DEL_HI
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

  // per cell status seen by the neighbors and the reduction
  typedef struct packed {
    logic lt;
    logic lo_hit;
    logic hi_hit;
  } cell_flags_t;

endpackage

`default_nettype wire

### hdl/nvm_cell.sv
// ----------------------------------------------------------------------------
// nvm_cell
// one slot of the sorted store: holds a value, compares it, shifts left/right
// ----------------------------------------------------------------------------
`default_nettype none

module nvm_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire nvm_pkg::cell_cmd_t         cmd_i,
  input  wire logic                       valid_i,
  input  wire logic                       lt_left_i,
  input  wire logic                       lt_right_i,
  input  wire logic [nvm_pkg::VAL_W-1:0]  val_left_i,
  input  wire logic [nvm_pkg::VAL_W-1:0]  val_right_i,
  output      logic [nvm_pkg::VAL_W-1:0]  val_o,
  output      nvm_pkg::cell_flags_t       flags_o
);
  import nvm_pkg::*;

  logic [VAL_W-1:0] val_q;
  logic             lt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
    end else if (cmd_i.op == OP_CMP) begin
      lt_q <= valid_i && (val_q < cmd_i.value);
    end
  end

  // value register, no reset
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_INS: begin
        if (!lt_q) begin
          val_q <= lt_left_i ? cmd_i.value : val_left_i;
        end
      end
      OP_DEL_LO: begin
        if (!lt_q || !lt_right_i) begin
          val_q <= val_right_i;
        end
      end
      OP_DEL_HI: begin
        if (!lt_q) begin
          val_q <= val_right_i;
        end
      end
      default: begin
        val_q <= val_q;
      end
    endcase
  end

  assign val_o          = val_q;
  assign flags_o.lt     = lt_q;
  // last entry below the request value
  assign flags_o.lo_hit = lt_q && !lt_right_i;
  // first stored entry at or above the request value
  assign flags_o.hi_hit = !lt_q && valid_i && lt_left_i;

endmodule

`default_nettype wire

### hdl/nvm_chain.sv
// ----------------------------------------------------------------------------
// nvm_chain
// row of cells wired to their neighbors, plus the lower/upper neighbor pick
// ----------------------------------------------------------------------------
`default_nettype none

module nvm_chain #(
  parameter int unsigned CAPACITY = nvm_pkg::CAPACITY_DEF,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire nvm_pkg::cell_cmd_t         cmd_i,
  input  wire logic [CW-1:0]              count_i,
  output      logic [nvm_pkg::VAL_W-1:0]  lo_val_o,
  output      logic [nvm_pkg::VAL_W-1:0]  hi_val_o,
  output      logic                       have_lo_o,
  output      logic                       have_hi_o
);
  import nvm_pkg::*;

  logic [VAL_W-1:0] vals  [CAPACITY];
  cell_flags_t      flags [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             lt_left;
    logic             lt_right;
    logic [VAL_W-1:0] val_left;
    logic [VAL_W-1:0] val_right;

    if (i == 0) begin : g_first
      assign lt_left  = 1'b1;
      assign val_left = cmd_i.value;
    end else begin : g_mid_l
      assign lt_left  = flags[i-1].lt;
      assign val_left = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign lt_right  = 1'b0;
      assign val_right = vals[i];
    end else begin : g_mid_r
      assign lt_right  = flags[i+1].lt;
      assign val_right = vals[i+1];
    end

    nvm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd_i),
      .valid_i     (CW'(i) < count_i),
      .lt_left_i   (lt_left),
      .lt_right_i  (lt_right),
      .val_left_i  (val_left),
      .val_right_i (val_right),
      .val_o       (vals[i]),
      .flags_o     (flags[i])
    );
  end

  // at most one cell raises each hit, so an and-or picks its value
  always_comb begin
    lo_val_o  = '0;
    hi_val_o  = '0;
    have_lo_o = 1'b0;
    have_hi_o = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      lo_val_o  = lo_val_o | (vals[i] & {VAL_W{flags[i].lo_hit}});
      hi_val_o  = hi_val_o | (vals[i] & {VAL_W{flags[i].hi_hit}});
      have_lo_o = have_lo_o | flags[i].lo_hit;
      have_hi_o = have_hi_o | flags[i].hi_hit;
    end
  end

endmodule

`default_nettype wire

### hdl/nearest_value_matcher.sv
// ----------------------------------------------------------------------------
// nearest_value_matcher
// sorted store of waiting values with nearest neighbor matching of requests
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Each item passes
// through the busy states (compare in every cell, pick the lower and
// upper neighbors, decide insert or match, shift the cell chain); in the
// cycle after the shift busy_o is low, the result shows with done_o high and
// the next item may already be started. Every cell compares in parallel,
// then the whole row shifts in one step.
// The result is on the ports for exactly one cycle; the receiver cannot
// stall, so it must take it when done_o is high. The store lives in the cell
// registers and needs no clearing pass after reset; of the store state, only
// the fill count, the waiting kind and the running total are cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_value_matcher #(
  parameter int unsigned CAPACITY = nvm_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output      logic                         busy_o,
  input  wire logic                         kind_i,
  input  wire logic [nvm_pkg::VAL_W-1:0]    value_i,
  output      logic                         done_o,
  output      logic                         matched_o,
  output      logic [nvm_pkg::VAL_W-1:0]    partner_value_o,
  output      logic [nvm_pkg::VAL_W-1:0]    distance_o,
  output      logic [nvm_pkg::TOTAL_W-1:0]  running_total_o,
  output      logic                         overflow_o,
  output      logic [nvm_pkg::FILL_W-1:0]   fill_o,
  output      logic                         waiting_kind_o
);
  import nvm_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // count widened so the fill port can take its low bits at any capacity
  localparam int unsigned WW = (CW > FILL_W) ? CW : FILL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEL,
    ST_DEC,
    ST_UPD
  } state_e;

  state_e             state_q;

  // item being worked on
  logic               kind_q;
  logic [VAL_W-1:0]   v_q;

  // store state outside the cells
  logic [CW-1:0]      count_q;
  logic               stored_kind_q;
  logic [TOTAL_W-1:0] total_q;

  // neighbor pick from the chain
  logic [VAL_W-1:0]   lo_val, hi_val;
  logic               have_lo, have_hi;
  logic [VAL_W-1:0]   lo_q, hi_q;
  logic               have_lo_q, have_hi_q;

  // decision
  cell_op_e           op_q;
  logic               match_q;
  logic               ovf_q;
  logic [VAL_W-1:0]   partner_q;
  logic [VAL_W-1:0]   dist_q;

  // decide-cycle logic
  logic               do_insert;
  logic               is_full;
  logic [VAL_W-1:0]   dlo, dhi;
  logic               pick_lo;

  // update-cycle logic
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_d;
  logic [CW-1:0]      count_d;
  logic [WW-1:0]      count_wide;

  cell_cmd_t          cmd;

  // registered output copies
  logic               done_q;
  logic               matched_q;
  logic [VAL_W-1:0]   partner_out_q;
  logic [VAL_W-1:0]   dist_out_q;
  logic               ovf_out_q;
  logic [FILL_W-1:0]  fill_q;

  // the chain compares in the compare state and shifts in the update state
  always_comb begin
    cmd.value = v_q;
    unique case (state_q)
      ST_CMP:  cmd.op = OP_CMP;
      ST_UPD:  cmd.op = op_q;
      default: cmd.op = OP_HOLD;
    endcase
  end

  nvm_chain #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .count_i   (count_q),
    .lo_val_o  (lo_val),
    .hi_val_o  (hi_val),
    .have_lo_o (have_lo),
    .have_hi_o (have_hi)
  );

  // insert when the store is empty or holds the same kind
  assign do_insert = (count_q == '0) || (kind_q == stored_kind_q);
  assign is_full   = (count_q == CW'(CAPACITY));
  // lower neighbor is below the value, upper one at or above it
  assign dlo       = v_q - lo_q;
  assign dhi       = hi_q - v_q;
  // tie goes to the smaller stored value
  assign pick_lo   = have_lo_q && (!have_hi_q || (dlo <= dhi));

  // saturating running total
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(dist_q);
  assign total_d   = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

  always_comb begin
    count_d = count_q;
    if (op_q == OP_INS) begin
      count_d = count_q + CW'(1);
    end else if (match_q) begin
      count_d = count_q - CW'(1);
    end
  end

  assign count_wide = WW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      kind_q        <= 1'b0;
      v_q           <= '0;
      count_q       <= '0;
      stored_kind_q <= 1'b0;
      total_q       <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      have_lo_q     <= 1'b0;
      have_hi_q     <= 1'b0;
      op_q          <= OP_HOLD;
      match_q       <= 1'b0;
      ovf_q         <= 1'b0;
      partner_q     <= '0;
      dist_q        <= '0;
      done_q        <= 1'b0;
      matched_q     <= 1'b0;
      partner_out_q <= '0;
      dist_out_q    <= '0;
      ovf_out_q     <= 1'b0;
      fill_q        <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            kind_q  <= kind_i;
            v_q     <= value_i;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_q <= ST_SEL;
        end
        ST_SEL: begin
          lo_q      <= lo_val;
          hi_q      <= hi_val;
          have_lo_q <= have_lo;
          have_hi_q <= have_hi;
          state_q   <= ST_DEC;
        end
        ST_DEC: begin
          if (do_insert) begin
            op_q      <= is_full ? OP_HOLD : OP_INS;
            ovf_q     <= is_full;
            match_q   <= 1'b0;
            partner_q <= '0;
            dist_q    <= '0;
          end else begin
            op_q      <= pick_lo ? OP_DEL_LO : OP_DEL_HI;
            ovf_q     <= 1'b0;
            match_q   <= 1'b1;
            partner_q <= pick_lo ? lo_q : hi_q;
            dist_q    <= pick_lo ? dlo : dhi;
          end
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          count_q <= count_d;
          total_q <= total_d;
          if (op_q == OP_INS) begin
            stored_kind_q <= kind_q;
          end
          done_q        <= 1'b1;
          matched_q     <= match_q;
          partner_out_q <= partner_q;
          dist_out_q    <= dist_q;
          ovf_out_q     <= ovf_q;
          fill_q        <= count_wide[FILL_W-1:0];
          state_q       <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign matched_o       = matched_q;
  assign partner_value_o = partner_out_q;
  assign distance_o      = dist_out_q;
  assign running_total_o = total_q;
  assign overflow_o      = ovf_out_q;
  assign fill_o          = fill_q;
  assign waiting_kind_o  = stored_kind_q;

  // a result never shows while an item is still at work
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // a request either matches or overflows, never both
  a_match_xor_ovf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(matched_o && overflow_o))
    else $error("match and overflow in one result");

  // the fill count stays within the store
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // a match needs a stored value of the other kind
  a_match_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC && !do_insert) |-> (have_lo_q || have_hi_q))
    else $error("match with no neighbor found");

  // overflow only when the store was full
  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |-> (count_q == CW'(CAPACITY)))
    else $error("overflow with room left");

endmodule

`default_nettype wire
